// ----- rtl/core/bit_range_block_reframer_assert.svh -----
// assertion macros for the block reframer
`ifndef BIT_RANGE_BLOCK_REFRAMER_ASSERT_SVH
`define BIT_RANGE_BLOCK_REFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define BRBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// condition must never be seen outside reset
`define BRBR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define BRBR_ASSERT(name, prop, msg)
`define BRBR_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ----- rtl/core/brbr_pkg.sv -----
// shared types and constants of the block reframer
`default_nettype none

package brbr_pkg;

  localparam int LENGTH_BITS_DEF = 26;

  localparam logic [47:0] BLOCK_MAGIC = 48'h314159265359;
  localparam logic [47:0] EOS_MAGIC   = 48'h177245385090;
  localparam logic [23:0] HDR_BZH     = 24'h425A68;
  localparam logic [7:0]  DIGIT_BASE  = 8'h30;

  localparam int MAGIC_BITS    = 48;
  localparam int CRC_END       = 80;
  localparam int MIN_BITS      = 80;
  localparam int MAGIC_BYTES   = 10;
  localparam int TRAILER_BYTES = 10;
  localparam int BURST_BYTES   = 12;
  localparam int BURST_W       = 8 * BURST_BYTES;
  localparam int CNT_W         = $clog2(BURST_BYTES + 1);

  localparam logic [3:0] LEVEL_RESET = 4'd9;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_STREAM,
    PH_DONE
  } phase_e;

  // stream state carried from byte to byte
  typedef struct packed {
    phase_e      phase;
    logic [6:0]  hold;
    logic [47:0] magic;
    logic [31:0] crc;
  } state_t;

  // result beats produced by one input byte, first beat in the top byte
  typedef struct packed {
    logic [BURST_W-1:0] data;
    logic [CNT_W-1:0]   cnt;
    logic               fin;
    logic               err;
  } burst_t;

endpackage

`default_nettype wire

// ----- rtl/core/brbr_step.sv -----
// one byte step: next stream state and the result beats of that byte
`default_nettype none

module brbr_step
  import brbr_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  state_t                 cur_i,
  input  logic [LENGTH_BITS-1:0] bc_i,
  input  logic [7:0]             data_byte_i,
  input  logic [3:0]             level_i,
  input  logic [2:0]             offset_i,
  input  logic [LENGTH_BITS-1:0] nbits_i,
  output state_t                 nxt_o,
  output logic [LENGTH_BITS-1:0] bc_o,
  output burst_t                 burst_o
);

  localparam int TAIL_W = 128;

  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

  // magic search
  logic [3:0]             n_avail;
  logic [7:0]             avail;
  logic [LENGTH_BITS-1:0] need;
  logic                   hit;
  logic [3:0]             ka;
  logic [3:0]             ra;
  logic [7:0]             take;
  logic [7:0]             rest;
  logic [47:0]            magic_new;

  // streaming
  logic [LENGTH_BITS-1:0] remain;
  logic                   fin_now;
  logic [3:0]             ks;
  logic [7:0]             newbits;
  logic [LENGTH_BITS-1:0] room_crc;
  logic [3:0]             c;
  logic [31:0]            crc_new;
  logic [14:0]            w;
  logic [3:0]             t;
  logic [6:0]             hold_mask;
  logic [TAIL_W-1:0]      tail;

  assign n_avail   = (bc_i == '0) ? (4'd8 - {1'b0, offset_i}) : 4'd8;
  assign avail     = data_byte_i & low_mask(n_avail);
  assign need      = LENGTH_BITS'(MAGIC_BITS) - bc_i;
  assign hit       = need <= LENGTH_BITS'(n_avail);
  assign ka        = hit ? need[3:0] : n_avail;
  assign ra        = n_avail - ka;
  assign take      = avail >> ra;
  assign rest      = avail & low_mask(ra);
  assign magic_new = (cur_i.magic << ka) | {40'b0, take};

  assign remain   = nbits_i - bc_i;
  assign fin_now  = remain <= LENGTH_BITS'(8);
  assign ks       = fin_now ? remain[3:0] : 4'd8;
  assign newbits  = data_byte_i >> (4'd8 - ks);
  assign room_crc = LENGTH_BITS'(CRC_END) - bc_i;
  assign c        = (bc_i >= LENGTH_BITS'(CRC_END)) ? 4'd0 :
                    ((room_crc >= LENGTH_BITS'(ks)) ? ks : room_crc[3:0]);
  assign crc_new  = (cur_i.crc << c) | ({24'b0, newbits} >> (ks - c));
  assign w        = ({8'b0, cur_i.hold} << ks) | {7'b0, newbits};
  assign t        = {1'b0, bc_i[2:0]} + ks;
  // bits still pending once a full byte has gone out
  assign hold_mask = 7'(low_mask(t - 4'd8));
  // pending bits, end magic, crc and zero pad, left aligned
  assign tail     = {1'b0, w, EOS_MAGIC, crc_new, 32'b0} << (5'd16 - {1'b0, t});

  always_comb begin
    nxt_o   = cur_i;
    bc_o    = bc_i;
    burst_o = '0;
    case (cur_i.phase)
      PH_AWAIT: begin
        if (hit) begin
          if (magic_new == BLOCK_MAGIC) begin
            nxt_o.phase = PH_STREAM;
            nxt_o.magic = magic_new;
            nxt_o.hold  = rest[6:0];
            nxt_o.crc   = {24'b0, rest};
            bc_o        = bc_i + LENGTH_BITS'(n_avail);
            burst_o.data = {HDR_BZH, DIGIT_BASE + {4'b0, level_i}, BLOCK_MAGIC, 16'b0};
            burst_o.cnt  = CNT_W'(MAGIC_BYTES);
          end else begin
            nxt_o.phase = PH_DONE;
            bc_o        = bc_i + LENGTH_BITS'(ka);
            burst_o.cnt = CNT_W'(1);
            burst_o.fin = 1'b1;
            burst_o.err = 1'b1;
          end
        end else begin
          nxt_o.magic = magic_new;
          bc_o        = bc_i + LENGTH_BITS'(n_avail);
        end
      end
      PH_STREAM: begin
        nxt_o.crc = crc_new;
        bc_o      = bc_i + LENGTH_BITS'(ks);
        if (fin_now) begin
          nxt_o.phase  = PH_DONE;
          nxt_o.hold   = '0;
          burst_o.data = tail[TAIL_W-1 -: BURST_W];
          burst_o.fin  = 1'b1;
          if (t == 4'd0) begin
            burst_o.cnt = CNT_W'(TRAILER_BYTES);
          end else if (t <= 4'd8) begin
            burst_o.cnt = CNT_W'(TRAILER_BYTES + 1);
          end else begin
            burst_o.cnt = CNT_W'(TRAILER_BYTES + 2);
          end
        end else if (t >= 4'd8) begin
          burst_o.data = {8'(w >> (t - 4'd8)), {(BURST_W - 8){1'b0}}};
          burst_o.cnt  = CNT_W'(1);
          nxt_o.hold   = w[6:0] & hold_mask;
        end else begin
          nxt_o.hold = w[6:0];
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/bit_range_block_reframer.sv -----
// top level: cuts one compressed block out of a byte stream and reframes it
// path: an accepted byte goes through the input register into the result buffer
// throughput: one byte per cycle when the output does not stall; the header burst
//   (10 beats) and trailer burst (10-12 beats) hold the input as the buffer drains
// reset: stream state cleared, level 9, start offset 0, block length 80 bits
// any register write restarts the stream state and keeps the registers
`default_nettype none

`include "bit_range_block_reframer_assert.svh"

module bit_range_block_reframer
  import brbr_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [LENGTH_BITS-1:0] cfg_data_i,
  // compressed file bytes
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  // rebuilt stream bytes
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_o,
  output logic                   status_o
);

  // configuration registers; the length is kept already clamped to at least 80 bits
  logic [3:0]             lvl_q;
  logic [2:0]             off_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic                   cfg_we;
  logic                   restart;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_accept;

  // stream state
  state_t                 st_q;
  state_t                 st_d;
  logic [LENGTH_BITS-1:0] bc_q;
  logic [LENGTH_BITS-1:0] bc_d;

  // result buffer, drained one beat per cycle from the top byte while the output does not stall
  burst_t burst;
  burst_t buf_q;
  logic   room;
  logic   proc_go;
  logic   pop;

  // config channel never blocks
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && ((cfg_index_i == CFG_LEVEL) ||
                                  (cfg_index_i == CFG_OFFSET) ||
                                  (cfg_index_i == CFG_LENGTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LEVEL_RESET;
      off_q <= '0;
      len_q <= LENGTH_BITS'(MIN_BITS);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_LEVEL:  lvl_q <= cfg_data_i[3:0];
        CFG_OFFSET: off_q <= cfg_data_i[2:0];
        CFG_LENGTH: begin
          // short lengths behave as the minimum block of magic plus crc
          len_q <= (cfg_data_i < LENGTH_BITS'(MIN_BITS)) ? LENGTH_BITS'(MIN_BITS)
                                                         : cfg_data_i;
        end
        default: begin
          lvl_q <= lvl_q;
        end
      endcase
    end
  end

  // a byte leaves the input register when the buffer is empty or is
  // handing over its last beat in this cycle
  assign pop       = out_valid_o && !out_stall_i;
  assign room      = (buf_q.cnt == '0) || ((buf_q.cnt == CNT_W'(1)) && !out_stall_i);
  assign proc_go   = in_vld_q && room;
  assign in_stall_o = in_vld_q && !proc_go;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (proc_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
    end
  end

  // all work for one byte happens here, between input register and buffer
  brbr_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .cur_i       (st_q),
    .bc_i        (bc_q),
    .data_byte_i (in_byte_q),
    .level_i     (lvl_q),
    .offset_i    (off_q),
    .nbits_i     (len_q),
    .nxt_o       (st_d),
    .bc_o        (bc_d),
    .burst_o     (burst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_AWAIT, hold: '0, magic: '0, crc: '0};
      bc_q <= '0;
    end else if (restart) begin
      st_q <= '{phase: PH_AWAIT, hold: '0, magic: '0, crc: '0};
      bc_q <= '0;
    end else if (proc_go) begin
      st_q <= st_d;
      bc_q <= bc_d;
    end
  end

  // a new burst replaces the buffer only once it is empty or emptying
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
    end else if (proc_go && (burst.cnt != '0)) begin
      buf_q <= burst;
    end else if (pop) begin
      buf_q.data <= {buf_q.data[BURST_W-9:0], 8'b0};
      buf_q.cnt  <= buf_q.cnt - CNT_W'(1);
    end
  end

  assign out_valid_o = buf_q.cnt != '0;
  assign out_byte_o  = buf_q.data[BURST_W-1 -: 8];
  assign last_o      = buf_q.fin && (buf_q.cnt == CNT_W'(1));
  assign status_o    = buf_q.err;

  // error beat is always the only and final beat of its burst
  `BRBR_ASSERT(a_err_is_last, (out_valid_o && status_o) |-> last_o, "error beat without last")
  // a byte held in the input register waits unchanged
  `BRBR_ASSERT(a_hold_input, (in_vld_q && !proc_go) |=> (in_vld_q && $stable(in_byte_q)),
    "held input byte lost")
  // buffer count stays within the longest burst
  `BRBR_ASSERT_NEVER(a_cnt_range, buf_q.cnt > CNT_W'(BURST_BYTES), "burst count overflow")

endmodule

`default_nettype wire
